### rtl/twtm_pkg.sv
// Shared types and constants for the time window table unit.
// Used by the window RAM users and the top level.
package twtm_pkg;
	localparam int MAX_WINDOWS = 64;
	localparam int TIME_BITS   = 40;
	localparam int IDX_W       = $clog2(MAX_WINDOWS);
	localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_QUERY  = 2'd3;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_NOCLOCK = 2'd1;
	localparam logic [1:0] ERR_NODATA  = 2'd2;

	typedef struct packed {
		logic [TIME_BITS-1:0] start;
		logic [TIME_BITS-1:0] finish;
		logic [1:0]           kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage

### rtl/time_window_table_merge_query_unit.sv
// Top level of the time window table unit: window table, sort, merge, query.
// Depends on twtm_pkg and twtm_ram.
//
// Pulse start while busy is low to issue a word. Exactly one result per word
// is shown for one cycle with done high; it cannot be held off. Clear, add and
// queries that fail the clock or data check finish straight from idle. A query
// skips each window that has already ended. Finish runs an insertion sort and a
// merge through the single-port-read window RAM. No reset sweep is needed.
module time_window_table_merge_query_unit
	import twtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [TIME_BITS-1:0] win_begin,
	input  logic [TIME_BITS-1:0] win_finish,
	input  logic [1:0]           win_kind,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic                 clock_valid,
	input  logic                 data_present,
	output logic                 done,
	output logic                 in_window,
	output logic [TIME_BITS-1:0] next_change,
	output logic                 next_on,
	output logic [1:0]           error_code,
	output logic [6:0]           table_count
);
	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SRK  = 10'b0000000010,
		ST_SKW  = 10'b0000000100,
		ST_SCMP = 10'b0000001000,
		ST_SPUT = 10'b0000010000,
		ST_MR0  = 10'b0000100000,
		ST_ML0  = 10'b0001000000,
		ST_MCMP = 10'b0010000000,
		ST_MFIN = 10'b0100000000,
		ST_QCMP = 10'b1000000000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q, scan_q, i_q, pos_q, kidx_q;
	entry_t               key_q, kept_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 done_q, in_window_q, next_on_q;
	logic [TIME_BITS-1:0] next_change_q;
	logic [1:0]           error_code_q;
	logic [CNT_W-1:0]     tcount_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr, raddr;
	entry_t               wdata, rd;
	logic [ENTRY_W-1:0]   rdata_raw;
	logic                 add_ok, shift_up, do_merge;
	logic [CNT_W-1:0]     i_nx, scan_nx, pos_m2;

	assign rd       = entry_t'(rdata_raw);
	assign add_ok   = (win_finish > win_begin) && (count_q < CNT_W'(MAX_WINDOWS));
	assign shift_up = rd.start > key_q.start;
	assign do_merge = rd.start <= kept_q.finish;
	assign i_nx     = i_q + CNT_W'(1);
	assign scan_nx  = scan_q + CNT_W'(1);
	assign pos_m2   = pos_q - CNT_W'(2);

	twtm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOWS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[IDX_W-1:0];
		wdata = key_q;
		raddr = i_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				raddr = scan_q[IDX_W-1:0];
				if (start && func == FUNC_ADD && add_ok) begin
					we    = 1'b1;
					waddr = count_q[IDX_W-1:0];
					wdata = '{start: win_begin, finish: win_finish, kind: win_kind};
				end
			end
			ST_SRK:  raddr = i_q[IDX_W-1:0];
			ST_SKW:  raddr = IDX_W'(i_q - CNT_W'(1));
			ST_SCMP: begin
				we    = 1'b1;
				raddr = pos_m2[IDX_W-1:0];
				if (shift_up) begin
					wdata = rd;
				end
			end
			ST_SPUT: begin
				we    = 1'b1;
				waddr = '0;
			end
			ST_MR0:  raddr = '0;
			ST_ML0:  raddr = IDX_W'(1);
			ST_MCMP: begin
				raddr = i_nx[IDX_W-1:0];
				waddr = kidx_q[IDX_W-1:0];
				wdata = kept_q;
				we    = !do_merge;
			end
			ST_MFIN: begin
				we    = 1'b1;
				waddr = kidx_q[IDX_W-1:0];
				wdata = kept_q;
			end
			ST_QCMP: raddr = scan_nx[IDX_W-1:0];
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			scan_q        <= '0;
			i_q           <= '0;
			pos_q         <= '0;
			kidx_q        <= '0;
			key_q         <= '0;
			kept_q        <= '0;
			now_q         <= '0;
			done_q        <= 1'b0;
			in_window_q   <= 1'b0;
			next_on_q     <= 1'b0;
			next_change_q <= '0;
			error_code_q  <= ERR_OK;
			tcount_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						in_window_q   <= 1'b0;
						next_on_q     <= 1'b0;
						next_change_q <= '0;
						error_code_q  <= ERR_OK;
						tcount_q      <= count_q;
						now_q         <= now_time;
						case (func)
							FUNC_CLEAR: begin
								count_q  <= '0;
								scan_q   <= '0;
								tcount_q <= '0;
								done_q   <= 1'b1;
							end
							FUNC_ADD: begin
								if (add_ok) begin
									count_q  <= count_q + CNT_W'(1);
									tcount_q <= count_q + CNT_W'(1);
								end
								done_q <= 1'b1;
							end
							FUNC_FINISH: begin
								if (count_q >= CNT_W'(2)) begin
									i_q     <= CNT_W'(1);
									state_q <= ST_SRK;
								end else begin
									scan_q <= '0;
									done_q <= 1'b1;
								end
							end
							default: begin
								if (!clock_valid) begin
									error_code_q <= ERR_NOCLOCK;
									done_q       <= 1'b1;
								end else if (!data_present) begin
									error_code_q <= ERR_NODATA;
									done_q       <= 1'b1;
								end else if (scan_q < count_q) begin
									state_q <= ST_QCMP;
								end else begin
									done_q <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_SRK: state_q <= ST_SKW;
				ST_SKW: begin
					key_q   <= rd;
					pos_q   <= i_q;
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (shift_up) begin
						pos_q <= pos_q - CNT_W'(1);
						if (pos_q == CNT_W'(1)) begin
							state_q <= ST_SPUT;
						end
					end else if (i_nx < count_q) begin
						i_q     <= i_nx;
						state_q <= ST_SRK;
					end else begin
						state_q <= ST_MR0;
					end
				end
				ST_SPUT: begin
					if (i_nx < count_q) begin
						i_q     <= i_nx;
						state_q <= ST_SRK;
					end else begin
						state_q <= ST_MR0;
					end
				end
				ST_MR0: state_q <= ST_ML0;
				ST_ML0: begin
					kept_q  <= rd;
					kidx_q  <= '0;
					i_q     <= CNT_W'(1);
					state_q <= ST_MCMP;
				end
				ST_MCMP: begin
					if (do_merge) begin
						if (rd.finish > kept_q.finish) begin
							kept_q.finish <= rd.finish;
						end
						kept_q.kind <= kept_q.kind | rd.kind;
					end else begin
						kidx_q <= kidx_q + CNT_W'(1);
						kept_q <= rd;
					end
					if (i_nx < count_q) begin
						i_q <= i_nx;
					end else begin
						state_q <= ST_MFIN;
					end
				end
				ST_MFIN: begin
					count_q  <= kidx_q + CNT_W'(1);
					tcount_q <= kidx_q + CNT_W'(1);
					scan_q   <= '0;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_QCMP: begin
					if (now_q >= rd.finish) begin
						// skip a window that has already ended
						scan_q <= scan_nx;
						if (scan_nx >= count_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						if (now_q >= rd.start) begin
							in_window_q   <= 1'b1;
							next_change_q <= rd.finish;
						end else begin
							next_change_q <= rd.start;
							next_on_q     <= 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign in_window   = in_window_q;
	assign next_change = next_change_q;
	assign next_on     = next_on_q;
	assign error_code  = error_code_q;
	assign table_count = 7'(tcount_q);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOWS))
		else $error("table count above capacity");
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word produced neither work nor result");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (error_code == ERR_OK || error_code == ERR_NOCLOCK ||
			error_code == ERR_NODATA))
		else $error("bad error code");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error_code != ERR_OK) |-> (!in_window && !next_on))
		else $error("error result with window flags");
endmodule

### rtl/twtm_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module twtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### tb/sv/twtm_checker.sv
// Checker for the time window table unit: predicts each result word and compares it.
// Depends on twtm_pkg; watches the command and result channels of the block.
module twtm_checker
	import twtm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           func,
	input  logic [TIME_BITS-1:0] win_begin,
	input  logic [TIME_BITS-1:0] win_finish,
	input  logic [1:0]           win_kind,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic                 clock_valid,
	input  logic                 data_present,
	input  logic                 done,
	input  logic                 in_window,
	input  logic [TIME_BITS-1:0] next_change,
	input  logic                 next_on,
	input  logic [1:0]           error_code,
	input  logic [6:0]           table_count,
	output int                   fail_count,
	output int                   pending,
	output int                   words_in,
	output int                   queries_hit
);
	typedef struct packed {
		logic                 in_win;
		logic [TIME_BITS-1:0] change;
		logic                 on;
		logic [1:0]           err;
		logic [6:0]           count;
	} answer_t;

	entry_t  windows[MAX_WINDOWS];
	int      n_windows;
	int      scan_pos;
	answer_t answers_due[$];

	assign pending = answers_due.size();

	function automatic void sort_and_merge();
		entry_t key;
		int     pos;
		int     kept;
		for (int i = 1; i < n_windows; i++) begin
			key = windows[i];
			pos = i;
			while (pos > 0 && windows[pos-1].start > key.start) begin
				windows[pos] = windows[pos-1];
				pos--;
			end
			windows[pos] = key;
		end
		if (n_windows > 1) begin
			kept = 0;
			for (int i = 1; i < n_windows; i++) begin
				if (windows[i].start <= windows[kept].finish) begin
					if (windows[i].finish > windows[kept].finish)
						windows[kept].finish = windows[i].finish;
					windows[kept].kind = windows[kept].kind | windows[i].kind;
				end else begin
					kept++;
					windows[kept] = windows[i];
				end
			end
			n_windows = kept + 1;
		end
		scan_pos = 0;
	endfunction

	function automatic answer_t window_answer();
		answer_t a;
		a = '0;
		case (func)
			FUNC_CLEAR: begin
				n_windows = 0;
				scan_pos = 0;
			end
			FUNC_ADD: begin
				if (win_finish > win_begin && n_windows < MAX_WINDOWS) begin
					windows[n_windows] = '{win_begin, win_finish, win_kind};
					n_windows++;
				end
			end
			FUNC_FINISH: sort_and_merge();
			default: begin
				if (!clock_valid)
					a.err = ERR_NOCLOCK;
				else if (!data_present)
					a.err = ERR_NODATA;
				else begin
					while (scan_pos < n_windows && now_time >= windows[scan_pos].finish)
						scan_pos++;
					if (scan_pos < n_windows) begin
						if (now_time >= windows[scan_pos].start) begin
							a.in_win = 1'b1;
							a.change = windows[scan_pos].finish;
						end else begin
							a.change = windows[scan_pos].start;
							a.on = 1'b1;
						end
					end
				end
			end
		endcase
		a.count = n_windows[6:0];
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		answer_t got;
		if (!arst_n) begin
			n_windows = 0;
			scan_pos = 0;
			answers_due.delete();
			fail_count = 0;
			words_in = 0;
			queries_hit = 0;
		end else begin
			got = '{in_window, next_change, next_on, error_code, table_count};
			if (done) begin
				if (answers_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", got);
				end else begin
					exp_a = answers_due.pop_front();
					if (got !== exp_a) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: in_window %b/%b next_change %h/%h next_on %b/%b err %0d/%0d count %0d/%0d (exp/got)",
								exp_a.in_win, got.in_win, exp_a.change, got.change,
								exp_a.on, got.on, exp_a.err, got.err, exp_a.count, got.count);
					end
				end
			end
			if (start && !busy) begin
				exp_a = window_answer();
				if (func == FUNC_QUERY && exp_a.in_win)
					queries_hit++;
				answers_due.push_back(exp_a);
				words_in++;
			end
		end
	end
endmodule

### tb/sv/tb.sv
// Testbench top for the time window table unit: stimulus, watchdog and verdict.
// Depends on twtm_pkg, time_window_table_merge_query_unit and twtm_checker.
module tb;
	import twtm_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           func = FUNC_CLEAR;
	logic [TIME_BITS-1:0] win_begin = '0;
	logic [TIME_BITS-1:0] win_finish = '0;
	logic [1:0]           win_kind = '0;
	logic [TIME_BITS-1:0] now_time = '0;
	logic                 clock_valid = 1'b0;
	logic                 data_present = 1'b0;
	logic                 done;
	logic                 in_window;
	logic [TIME_BITS-1:0] next_change;
	logic                 next_on;
	logic [1:0]           error_code;
	logic [6:0]           table_count;
	int                   fail_count;
	int                   pending;
	int                   words_in;
	int                   queries_hit;
	int                   quiet_cycles;
	int                   idle_pct = 18;
	logic [TIME_BITS-1:0] clock_now;

	localparam int WATCHDOG = 200000;

	always #2 clk = ~clk;

	time_window_table_merge_query_unit u_top (.*);

	twtm_checker u_chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Hold the word until accepted, then drop start or pass to the next word.
	task automatic issue(input logic [1:0] f, input logic [TIME_BITS-1:0] b,
		input logic [TIME_BITS-1:0] e, input logic [1:0] k,
		input logic [TIME_BITS-1:0] t, input logic cv, input logic dp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		win_begin <= b;
		win_finish <= e;
		win_kind <= k;
		now_time <= t;
		clock_valid <= cv;
		data_present <= dp;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [TIME_BITS-1:0] rand_time();
		return TIME_BITS'({$urandom, $urandom});
	endfunction

	task automatic add_win(input logic [TIME_BITS-1:0] b, input logic [TIME_BITS-1:0] e,
		input logic [1:0] k);
		issue(FUNC_ADD, b, e, k, rand_time(), 1'($urandom), 1'($urandom));
	endtask

	task automatic ask(input logic [TIME_BITS-1:0] t);
		issue(FUNC_QUERY, rand_time(), rand_time(), 2'($urandom), t, 1'b1, 1'b1);
	endtask

	initial begin
		logic [TIME_BITS-1:0] base;
		logic [TIME_BITS-1:0] b;
		int                   n;
		int                   span;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, reversed and empty windows, errors, overlap, add after finish
		issue(FUNC_QUERY, '0, '0, 2'd0, '0, 1'b1, 1'b1);
		ask({TIME_BITS{1'b1}});
		issue(FUNC_QUERY, '0, '0, 2'd0, 40'd5, 1'b0, 1'b0);
		issue(FUNC_QUERY, '0, '0, 2'd0, 40'd5, 1'b1, 1'b0);
		add_win(40'd100, 40'd100, 2'd1);
		add_win(40'd200, 40'd100, 2'd1);
		add_win(40'd500, 40'd600, 2'd2);
		add_win(40'd100, 40'd200, 2'd1);
		add_win(40'd200, 40'd300, 2'd2);
		add_win(40'd250, 40'd280, 2'd3);
		add_win('0, 40'd1, 2'd0);
		add_win({TIME_BITS{1'b1}} - TIME_BITS'(1), {TIME_BITS{1'b1}}, 2'd3);
		issue(FUNC_FINISH, '0, '0, 2'd0, '0, 1'b1, 1'b1);
		ask('0);
		ask(40'd50);
		ask(40'd150);
		ask(40'd300);
		ask(40'd550);
		add_win(40'd10, 40'd20, 2'd1);
		ask(40'd700);
		ask({TIME_BITS{1'b1}} - TIME_BITS'(1));
		issue(FUNC_CLEAR, '0, '0, 2'd0, '0, 1'b1, 1'b1);
		ask(40'd0);
		// fill past capacity
		for (int i = 0; i < MAX_WINDOWS + 2; i++)
			add_win(rand_time() >> 1, rand_time() | {1'b1, {(TIME_BITS-1){1'b0}}},
				2'($urandom));
		issue(FUNC_FINISH, '0, '0, 2'd0, '0, 1'b1, 1'b1);
		ask(rand_time());

		// random: mostly well-formed build, finish, ascending queries
		while (words_in < 1000) begin
			idle_pct = (words_in > 500 && words_in < 650) ? 0 : 18;
			if ($urandom_range(9) == 0) begin
				issue(2'($urandom), rand_time(), rand_time(), 2'($urandom), rand_time(),
					1'($urandom), 1'($urandom));
			end else begin
				issue(FUNC_CLEAR, rand_time(), rand_time(), 2'($urandom), rand_time(),
					1'($urandom), 1'($urandom));
				n = ($urandom_range(7) == 0) ? int'($urandom_range(MAX_WINDOWS + 2))
					: int'($urandom_range(12));
				span = $urandom_range(3) == 0 ? 1000000 : 400;
				base = ($urandom_range(4) == 0) ? rand_time()
					: TIME_BITS'($urandom_range(1000));
				for (int i = 0; i < n; i++) begin
					b = base + TIME_BITS'($urandom_range(span));
					if ($urandom_range(9) == 0)
						add_win(b, b - TIME_BITS'($urandom_range(3)), 2'($urandom));
					else
						add_win(b, b + TIME_BITS'(1 + $urandom_range(span / 8)),
							2'($urandom));
				end
				issue(FUNC_FINISH, rand_time(), rand_time(), 2'($urandom), rand_time(),
					1'($urandom), 1'($urandom));
				clock_now = base;
				repeat ($urandom_range(1, 12)) begin
					clock_now = clock_now + TIME_BITS'($urandom_range(span / 6));
					issue(FUNC_QUERY, rand_time(), rand_time(), 2'($urandom), clock_now,
						$urandom_range(15) != 0, $urandom_range(15) != 0);
				end
			end
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (50) @(posedge clk);
		$display("%0d words issued, %0d queries found the time inside a window",
			words_in, queries_hit);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
